// File: rtl/core/fdmd_pkg.sv
package fdmd_pkg;

   // Capacity of the previous-frame store and the widths that follow from it.
   localparam int unsigned MAX_PIXELS = 524288;
   localparam int unsigned ADDR_W     = $clog2(MAX_PIXELS);
   localparam int unsigned POS_W      = ADDR_W + 1;

   // Pixel and field widths.
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned GRAY_W   = 8;
   localparam int unsigned COUNT_W  = 20;
   localparam int unsigned SHARE_W  = 15;
   localparam int unsigned THR_W    = 8;
   localparam int unsigned MTHR_W   = 20;

   // Fixed-point gray conversion: (1868*B + 9617*G + 4899*R + 8192) >> 14.
   localparam int unsigned GSUM_W     = 22;
   localparam int unsigned GRAY_SHIFT = 14;
   localparam logic [GSUM_W-1:0] COEF_B     = GSUM_W'(1868);
   localparam logic [GSUM_W-1:0] COEF_G     = GSUM_W'(9617);
   localparam logic [GSUM_W-1:0] COEF_R     = GSUM_W'(4899);
   localparam logic [GSUM_W-1:0] GRAY_ROUND = GSUM_W'(8192);

   // Changed share in units of 1/256 percent.
   localparam int unsigned SHARE_SCALE_W = 15;
   localparam logic [SHARE_SCALE_W-1:0] SHARE_SCALE = SHARE_SCALE_W'(25600);
   localparam int unsigned PROD_W   = COUNT_W + SHARE_SCALE_W;
   localparam int unsigned ITER_W   = $clog2(PROD_W);
   localparam logic [PROD_W-1:0] SHARE_MAX = PROD_W'(25600);

   // Frame record queue between pixel front end and result back end.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Control and status register port.
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_THRESHOLD  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_LIMIT     = CSR_INDEX_W'(1);
   localparam logic [THR_W-1:0]  PIXEL_THRESHOLD_RESET  = THR_W'(25);
   localparam logic [MTHR_W-1:0] MOTION_LIMIT_RESET     = MTHR_W'(2500);

   // Summary of one finished frame, passed from front end to back end.
   typedef struct packed {
      logic [COUNT_W-1:0] changed;
      logic [POS_W-1:0]   stored;
      logic               overflow;
   } frame_rec_type;

endpackage

// File: rtl/core/fdmd_ram.sv
module fdmd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port; registered read returns the contents before a same-cycle write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fdmd_front.sv
module fdmd_front import fdmd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic                req_end_of_frame,
   input  logic [THR_W-1:0]    pixel_threshold,
   input  logic [QCNT_W-1:0]   q_count,
   output logic                q_push,
   output frame_rec_type       q_rec
);

   // Accept-side frame state.
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               first_ff, first_in;
   logic               ovf_ff, ovf_in;

   // Compare stage, loaded by every accepted transaction.
   logic               s1_valid_ff;
   logic [GSUM_W-1:0]  s1_pb_ff, s1_pg_ff, s1_pr_ff;
   logic               s1_in_range_ff;
   logic               s1_eof_ff;
   logic               s1_first_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [POS_W-1:0]   s1_stored_ff;
   logic               s1_ovf_ff;
   logic               s1_hazard_ff;
   logic [GRAY_W-1:0]  s1_bypass_ff;

   logic [COUNT_W-1:0] count_ff, count_in;

   logic               accept;
   logic               in_range;
   logic [ADDR_W-1:0]  rd_addr;
   logic [GRAY_W-1:0]  rd_data;
   logic [GSUM_W-1:0]  gray_sum;
   logic [GRAY_W-1:0]  gray;
   logic [GRAY_W-1:0]  old_gray;
   logic [GRAY_W-1:0]  diff;
   logic               changed;
   logic [COUNT_W-1:0] count_next;
   logic               s1_push;
   logic               wr_en;

   assign in_range = (pos_ff < POS_W'(MAX_PIXELS));
   assign rd_addr  = pos_ff[ADDR_W-1:0];

   // A frame record is pending in the compare stage when it ends a reported frame.
   assign s1_push  = s1_valid_ff & s1_eof_ff & ~s1_first_ff;
   assign req_full = (q_count >= QCNT_W'(QUEUE_DEPTH)) ||
                     ((q_count == QCNT_W'(QUEUE_DEPTH - 1)) && s1_push);
   assign accept   = req_push & ~req_full;

   // Position, first-frame and overflow tracking at accept time.
   always_comb begin
      pos_in   = pos_ff;
      first_in = first_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_end_of_frame) begin
            pos_in   = '0;
            first_in = 1'b0;
            ovf_in   = 1'b0;
         end else if (in_range) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // Gray value, previous value with bypass for a same-address write, and the change test.
   assign gray_sum   = s1_pb_ff + s1_pg_ff + s1_pr_ff + GRAY_ROUND;
   assign gray       = gray_sum[GRAY_SHIFT +: GRAY_W];
   assign old_gray   = s1_hazard_ff ? s1_bypass_ff : rd_data;
   assign diff       = (gray > old_gray) ? (gray - old_gray) : (old_gray - gray);
   assign changed    = s1_in_range_ff & ~s1_first_ff & (diff > pixel_threshold);
   assign count_next = count_ff + COUNT_W'(changed);
   assign wr_en      = s1_valid_ff & s1_in_range_ff;

   always_comb begin
      count_in = count_ff;
      if (s1_valid_ff) begin
         count_in = s1_eof_ff ? '0 : count_next;
      end
   end

   assign q_push           = s1_push;
   assign q_rec.changed    = count_next;
   assign q_rec.stored     = s1_stored_ff;
   assign q_rec.overflow   = s1_ovf_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         first_ff    <= 1'b1;
         ovf_ff      <= 1'b0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         first_ff    <= first_in;
         ovf_ff      <= ovf_in;
         count_ff    <= count_in;
         s1_valid_ff <= accept;
      end
   end

   // Compare-stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pb_ff       <= GSUM_W'(req_blue) * COEF_B;
         s1_pg_ff       <= GSUM_W'(req_green) * COEF_G;
         s1_pr_ff       <= GSUM_W'(req_red) * COEF_R;
         s1_in_range_ff <= in_range;
         s1_eof_ff      <= req_end_of_frame;
         s1_first_ff    <= first_ff;
         s1_addr_ff     <= rd_addr;
         s1_stored_ff   <= in_range ? (pos_ff + POS_W'(1)) : pos_ff;
         s1_ovf_ff      <= ovf_ff | ~in_range;
         s1_hazard_ff   <= wr_en && (s1_addr_ff == rd_addr);
         s1_bypass_ff   <= gray;
      end
   end

   // Previous-frame gray store.
   fdmd_ram #(
      .WIDTH (GRAY_W),
      .DEPTH (MAX_PIXELS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (gray),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: rtl/core/fdmd_queue.sv
module fdmd_queue import fdmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  frame_rec_type     push_rec,
   input  logic              pop,
   output frame_rec_type     pop_rec,
   output logic              empty,
   output logic [QCNT_W-1:0] count
);

   frame_rec_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign pop_rec = entry_ff[rd_ptr_ff];
   assign do_pop  = pop & ~empty;

   // Pointers and fill count; the front end never pushes into a full queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// File: rtl/core/fdmd_back.sv
module fdmd_back import fdmd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  frame_rec_type       q_rec,
   output logic                q_pop,
   input  logic [MTHR_W-1:0]   motion_limit,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [COUNT_W-1:0]  rsp_changed_count,
   output logic                rsp_motion_detected,
   output logic [SHARE_W-1:0]  rsp_changed_share,
   output logic                rsp_capacity_exceeded
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_HOLD
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               motion_ff, motion_in;
   logic               ovf_ff, ovf_in;
   logic [POS_W-1:0]   stored_ff, stored_in;
   logic [PROD_W-1:0]  dividend_ff, dividend_in;
   logic [POS_W-1:0]   rem_ff, rem_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [SHARE_W-1:0] share_ff, share_in;

   logic [POS_W:0]     trial;
   logic               qbit;
   logic [PROD_W-1:0]  quotient;

   // One restoring-division step: shift in the next dividend bit and try the subtract.
   assign trial    = {rem_ff, dividend_ff[PROD_W-1]} - {1'b0, stored_ff};
   assign qbit     = ~trial[POS_W];
   assign quotient = {dividend_ff[PROD_W-2:0], qbit};

   assign q_pop                 = (state_ff == ST_IDLE) & ~q_empty;
   assign rsp_empty             = (state_ff != ST_HOLD);
   assign rsp_changed_count     = count_ff;
   assign rsp_motion_detected   = motion_ff;
   assign rsp_changed_share     = share_ff;
   assign rsp_capacity_exceeded = ovf_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      motion_in   = motion_ff;
      ovf_in      = ovf_ff;
      stored_in   = stored_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      iter_in     = iter_ff;
      share_in    = share_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               count_in  = q_rec.changed;
               stored_in = q_rec.stored;
               ovf_in    = q_rec.overflow;
               motion_in = (q_rec.changed > motion_limit);
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            dividend_in = PROD_W'(count_ff) * PROD_W'(SHARE_SCALE);
            rem_in      = '0;
            iter_in     = ITER_W'(PROD_W - 1);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            rem_in      = qbit ? trial[POS_W-1:0] : {rem_ff[POS_W-2:0], dividend_ff[PROD_W-1]};
            dividend_in = quotient;
            iter_in     = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               // Share is zero for an empty frame and never above one hundred percent.
               if (stored_ff == '0) begin
                  share_in = '0;
               end else if (quotient > SHARE_MAX) begin
                  share_in = SHARE_MAX[SHARE_W-1:0];
               end else begin
                  share_in = quotient[SHARE_W-1:0];
               end
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_pop) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff    <= count_in;
      motion_ff   <= motion_in;
      ovf_ff      <= ovf_in;
      stored_ff   <= stored_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      iter_ff     <= iter_in;
      share_ff    <= share_in;
   end

endmodule

// File: rtl/core/frame_difference_motion_detector_unit.sv
// Frame-difference motion detector.
// Pixels enter on the req_ channel, one transaction per pixel, with req_end_of_frame
// set on the last pixel of a frame. Each pixel is turned to gray, compared with the
// gray value stored at the same position for the previous frame, and stored.
// At the end of every frame but the first after reset, one transaction appears on
// the rsp_ channel with the changed count, the motion flag, the changed share in
// 1/256 percent and the capacity flag; other pixels give no result.
// Pixels are taken one per cycle while req_full is low; the pixel pipeline is
// two stages deep around the registered read of the frame store. A frame
// summary then waits in a two-entry queue for the result unit, which takes the
// summary, does one multiply and a 35-step restoring division, and holds the
// result until rsp_pop is high; it takes no new summary before then. req_full
// rises when the queue holds, or is taking, its second frame whose result is
// not yet taken, so a receiver that leaves rsp_pop low stalls the pixel stream
// after at most two more frame ends. Reset clears the counters and the queue and
// restores both thresholds; the frame store needs no clearing because the first
// frame after reset only fills it. The threshold registers on the csr_ channel
// are always ready.
module frame_difference_motion_detector_unit import fdmd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [CHAN_W-1:0]      req_blue,
   input  logic [CHAN_W-1:0]      req_green,
   input  logic [CHAN_W-1:0]      req_red,
   input  logic                   req_end_of_frame,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [COUNT_W-1:0]     rsp_changed_count,
   output logic                   rsp_motion_detected,
   output logic [SHARE_W-1:0]     rsp_changed_share,
   output logic                   rsp_capacity_exceeded,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [THR_W-1:0]  pixel_threshold_ff;
   logic [MTHR_W-1:0] motion_limit_ff;

   logic              q_push;
   frame_rec_type     q_push_rec;
   logic              q_pop;
   frame_rec_type     q_pop_rec;
   logic              q_empty;
   logic [QCNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   // Threshold registers; writes to other indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_threshold_ff <= PIXEL_THRESHOLD_RESET;
         motion_limit_ff    <= MOTION_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_THRESHOLD: pixel_threshold_ff <= csr_wdata[THR_W-1:0];
            CSR_MOTION_LIMIT:    motion_limit_ff    <= csr_wdata[MTHR_W-1:0];
            default: ;
         endcase
      end
   end

   // Pixel front end: gray conversion, frame store and changed count.
   fdmd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .req_end_of_frame (req_end_of_frame),
      .pixel_threshold  (pixel_threshold_ff),
      .q_count          (q_count),
      .q_push           (q_push),
      .q_rec            (q_push_rec)
   );

   // Frame summaries waiting for the result unit.
   fdmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_push_rec),
      .pop      (q_pop),
      .pop_rec  (q_pop_rec),
      .empty    (q_empty),
      .count    (q_count)
   );

   // Result unit: motion flag, share division and result register.
   fdmd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_empty               (q_empty),
      .q_rec                 (q_pop_rec),
      .q_pop                 (q_pop),
      .motion_limit          (motion_limit_ff),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_changed_count     (rsp_changed_count),
      .rsp_motion_detected   (rsp_motion_detected),
      .rsp_changed_share     (rsp_changed_share),
      .rsp_capacity_exceeded (rsp_capacity_exceeded)
   );

endmodule
